### rtl/core/ttd_pkg.sv
// ttd_pkg: shared widths, command and gesture codes and types for the
// touch tap/drag classifier. No dependencies.
`timescale 1ns / 1ps

package ttd_pkg;

  // coordinate and field widths
  localparam int COORD_BITS = 16;
  localparam int POS_W      = COORD_BITS + 1;
  localparam int VAL_W      = 17;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DIFF_W     = POS_W + 1;
  localparam int DIST_W     = DIFF_W + 1;
  localparam int CMP_W      = (DIST_W > CFG_W) ? DIST_W : CFG_W;

  // command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register reset values
  localparam logic [CFG_W-1:0] RESET_THRESHOLD = 16'd48;
  localparam logic [CFG_W-1:0] RESET_STEP      = 16'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP   = 2'd2;

  // incoming event kinds
  localparam logic [2:0] EV_X      = 3'd0;
  localparam logic [2:0] EV_Y      = 3'd1;
  localparam logic [2:0] EV_ID     = 3'd2;
  localparam logic [2:0] EV_BUTTON = 3'd3;
  localparam logic [2:0] EV_SYNC   = 3'd4;

  typedef logic signed [POS_W-1:0] pos_t;
  localparam pos_t POS_UNKNOWN = '1;

  // classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_SET_X = 3'd0,
    CMD_SET_Y = 3'd1,
    CMD_TRACK = 3'd2,
    CMD_PRESS = 3'd3,
    CMD_LIFT  = 3'd4,
    CMD_SYNC  = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    pos_t      pos;
  } cmd_t;

  // reported gesture codes
  typedef enum logic [2:0] {
    GK_TAP  = 3'd0,
    GK_DRAG = 3'd1,
    GK_DOWN = 3'd2,
    GK_MOVE = 3'd3,
    GK_UP   = 3'd4
  } gesture_t;

endpackage

### rtl/core/ttd_front.sv
// ttd_front: accepts touch events and classifies them into queue commands.
// Depends on ttd_pkg.
`timescale 1ns / 1ps

module ttd_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                event_kind,
  input  logic signed [ttd_pkg::VAL_W-1:0] event_value,
  input  logic                      q_ready,
  output logic                      q_push,
  output ttd_pkg::cmd_t             q_cmd
);

  logic keep;

  // accept whenever the queue has room; ignored kinds are dropped here
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && keep;

  // classify the event
  always_comb begin
    keep       = 1'b1;
    q_cmd.pos  = ttd_pkg::pos_t'(event_value);
    q_cmd.kind = ttd_pkg::CMD_SYNC;
    case (event_kind)
      ttd_pkg::EV_X: begin
        q_cmd.kind = ttd_pkg::CMD_SET_X;
      end
      ttd_pkg::EV_Y: begin
        q_cmd.kind = ttd_pkg::CMD_SET_Y;
      end
      ttd_pkg::EV_ID: begin
        if (event_value == '1) begin
          q_cmd.kind = ttd_pkg::CMD_LIFT;
        end else begin
          q_cmd.kind = ttd_pkg::CMD_TRACK;
        end
      end
      ttd_pkg::EV_BUTTON: begin
        if (event_value != '0) begin
          q_cmd.kind = ttd_pkg::CMD_PRESS;
        end else begin
          q_cmd.kind = ttd_pkg::CMD_LIFT;
        end
      end
      ttd_pkg::EV_SYNC: begin
        q_cmd.kind = ttd_pkg::CMD_SYNC;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/ttd_queue.sv
// ttd_queue: small command queue between classifier front and gesture back.
// Depends on ttd_pkg.
`timescale 1ns / 1ps

module ttd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          push_ready,
  input  ttd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          pop_valid,
  output ttd_pkg::cmd_t pop_cmd
);

  ttd_pkg::cmd_t               mem [ttd_pkg::QDEPTH];
  logic [ttd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ttd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ttd_pkg::QCNT_W-1:0]  count;

  assign push_ready = (count != ttd_pkg::QCNT_W'(ttd_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/ttd_back.sv
// ttd_back: gesture state, configuration registers and the result register.
// Depends on ttd_pkg.
`timescale 1ns / 1ps

module ttd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           q_valid,
  input  ttd_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     gesture_kind,
  output logic signed [ttd_pkg::VAL_W-1:0] start_x,
  output logic signed [ttd_pkg::VAL_W-1:0] start_y,
  output logic signed [ttd_pkg::VAL_W-1:0] end_x,
  output logic signed [ttd_pkg::VAL_W-1:0] end_y
);

  // configuration
  logic                      stream_mode;
  logic [ttd_pkg::CFG_W-1:0] drag_limit;
  logic [ttd_pkg::CFG_W-1:0] move_step;

  // gesture state
  ttd_pkg::pos_t cur_x, cur_y, press_x, press_y, moved_x, moved_y;
  logic          is_touching, press_seen, stream_active;

  ttd_pkg::pos_t cur_x_next, cur_y_next, press_x_next, press_y_next;
  ttd_pkg::pos_t moved_x_next, moved_y_next;
  logic          is_touching_next, press_seen_next, stream_active_next;

  // result of this command
  logic              res_fire;
  ttd_pkg::gesture_t res_kind;
  logic              res_start;
  ttd_pkg::gesture_t out_kind;

  ttd_pkg::pos_t               px, py;
  logic [ttd_pkg::DIFF_W-1:0]  adx, ady, mdx, mdy;
  logic [ttd_pkg::DIST_W-1:0]  mdist;
  logic                        cur_known, is_drag, step_hit;

  function automatic logic [ttd_pkg::DIFF_W-1:0] absdiff(ttd_pkg::pos_t a,
                                                         ttd_pkg::pos_t b);
    logic signed [ttd_pkg::DIFF_W:0] d;
    d = (ttd_pkg::DIFF_W + 1)'(a) - (ttd_pkg::DIFF_W + 1)'(b);
    return d[ttd_pkg::DIFF_W] ? ttd_pkg::DIFF_W'(-d) : ttd_pkg::DIFF_W'(d);
  endfunction

  function automatic logic [ttd_pkg::VAL_W-1:0] to_port(ttd_pkg::pos_t p);
    return ttd_pkg::VAL_W'($unsigned(p));
  endfunction

  assign q_pop = q_valid && (!out_valid || out_ready);

  // press point fix-up before the gesture check
  always_comb begin
    if (is_touching && press_seen && press_x[ttd_pkg::POS_W-1]) begin
      px = cur_x;
      py = cur_y;
    end else begin
      px = press_x;
      py = press_y;
    end
  end

  // distances
  assign adx       = absdiff(cur_x, px);
  assign ady       = absdiff(cur_y, py);
  assign mdx       = absdiff(cur_x, moved_x);
  assign mdy       = absdiff(cur_y, moved_y);
  assign mdist     = {1'b0, mdx} + {1'b0, mdy};
  assign cur_known = !cur_x[ttd_pkg::POS_W-1] && !cur_y[ttd_pkg::POS_W-1];
  assign is_drag   = !px[ttd_pkg::POS_W-1] &&
                     ((ttd_pkg::CMP_W'(adx) > ttd_pkg::CMP_W'(drag_limit)) ||
                      (ttd_pkg::CMP_W'(ady) > ttd_pkg::CMP_W'(drag_limit)));
  assign step_hit  = ttd_pkg::CMP_W'(mdist) >= ttd_pkg::CMP_W'(move_step);

  // next state for the popped command
  always_comb begin
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    press_x_next       = press_x;
    press_y_next       = press_y;
    moved_x_next       = moved_x;
    moved_y_next       = moved_y;
    is_touching_next   = is_touching;
    press_seen_next    = press_seen;
    stream_active_next = stream_active;
    res_fire           = 1'b0;
    res_kind           = ttd_pkg::GK_TAP;
    res_start          = 1'b0;
    case (q_cmd.kind)
      ttd_pkg::CMD_SET_X: begin
        cur_x_next = q_cmd.pos;
      end
      ttd_pkg::CMD_SET_Y: begin
        cur_y_next = q_cmd.pos;
      end
      ttd_pkg::CMD_TRACK, ttd_pkg::CMD_PRESS: begin
        if (q_cmd.kind == ttd_pkg::CMD_PRESS || !is_touching) begin
          is_touching_next = 1'b1;
          press_seen_next  = 1'b1;
          press_x_next     = cur_x;
          press_y_next     = cur_y;
        end
      end
      ttd_pkg::CMD_LIFT: begin
        is_touching_next = 1'b0;
      end
      ttd_pkg::CMD_SYNC: begin
        press_x_next = px;
        press_y_next = py;
        if (stream_mode) begin
          if (is_touching && !stream_active && cur_known) begin
            res_fire           = 1'b1;
            res_kind           = ttd_pkg::GK_DOWN;
            stream_active_next = 1'b1;
            moved_x_next       = cur_x;
            moved_y_next       = cur_y;
          end else if (is_touching && stream_active) begin
            if (step_hit) begin
              res_fire     = 1'b1;
              res_kind     = ttd_pkg::GK_MOVE;
              moved_x_next = cur_x;
              moved_y_next = cur_y;
            end
          end else if (!is_touching && stream_active) begin
            res_fire           = 1'b1;
            res_kind           = ttd_pkg::GK_UP;
            stream_active_next = 1'b0;
            press_seen_next    = 1'b0;
            press_x_next       = ttd_pkg::POS_UNKNOWN;
            press_y_next       = ttd_pkg::POS_UNKNOWN;
          end
        end else if (!is_touching && press_seen && cur_known) begin
          res_fire        = 1'b1;
          res_kind        = is_drag ? ttd_pkg::GK_DRAG : ttd_pkg::GK_TAP;
          res_start       = is_drag;
          press_seen_next = 1'b0;
          press_x_next    = ttd_pkg::POS_UNKNOWN;
          press_y_next    = ttd_pkg::POS_UNKNOWN;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_mode <= 1'b0;
      drag_limit  <= ttd_pkg::RESET_THRESHOLD;
      move_step   <= ttd_pkg::RESET_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        ttd_pkg::CFG_STREAM_MODE: stream_mode <= cfg_data[0];
        ttd_pkg::CFG_DRAG_LIMIT:  drag_limit  <= cfg_data;
        ttd_pkg::CFG_MOVE_STEP:   move_step   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // gesture state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= ttd_pkg::POS_UNKNOWN;
      cur_y         <= ttd_pkg::POS_UNKNOWN;
      press_x       <= ttd_pkg::POS_UNKNOWN;
      press_y       <= ttd_pkg::POS_UNKNOWN;
      moved_x       <= ttd_pkg::POS_UNKNOWN;
      moved_y       <= ttd_pkg::POS_UNKNOWN;
      is_touching   <= 1'b0;
      press_seen    <= 1'b0;
      stream_active <= 1'b0;
    end else if (q_pop) begin
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      press_x       <= press_x_next;
      press_y       <= press_y_next;
      moved_x       <= moved_x_next;
      moved_y       <= moved_y_next;
      is_touching   <= is_touching_next;
      press_seen    <= press_seen_next;
      stream_active <= stream_active_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (q_pop && res_fire) begin
      out_kind <= res_kind;
      start_x  <= res_start ? to_port(px) : '0;
      start_y  <= res_start ? to_port(py) : '0;
      end_x    <= to_port(cur_x);
      end_y    <= to_port(cur_y);
    end
  end

  assign gesture_kind = out_kind;

`ifndef ASSERT_OFF
  // start fields are only filled for a drag
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != ttd_pkg::GK_DRAG |-> start_x == '0 && start_y == '0)
    else $error("start fields set on a non-drag result");

  // a reported down opens the stream, a reported up closes it
  a_down_opens: assert property (@(posedge clk) disable iff (rst)
    q_pop && res_fire && res_kind == ttd_pkg::GK_DOWN |=> stream_active && out_valid)
    else $error("down result without active stream");

  a_up_closes: assert property (@(posedge clk) disable iff (rst)
    q_pop && res_fire && res_kind == ttd_pkg::GK_UP |=> !stream_active && !press_seen)
    else $error("up result left stream open");

  // a waiting result is never dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result lost");
`endif

endmodule

### rtl/core/touch_tap_drag_classifier.sv
// touch_tap_drag_classifier: top level; front classifier, command queue and
// gesture back end. Depends on ttd_pkg, ttd_front, ttd_queue, ttd_back.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   event   | in_valid / in_ready  | event_kind, event_value
//   gesture | out_valid / out_ready| gesture_kind, start_x/y, end_x/y
//   config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one event per cycle while the queue has room; the back end retires one queued
// command per cycle unless a result is held, and the output register loads on
// the edge that retires a sync, after the command has passed through the queue.
// reset (rst, synchronous) clears the queue, gesture state and registers.
// a held result stalls the back end; the two-entry queue keeps accepting until
// full. configuration writes are always taken.
`timescale 1ns / 1ps

module touch_tap_drag_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            event_kind,
  input  logic signed [ttd_pkg::VAL_W-1:0]      event_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            gesture_kind,
  output logic signed [ttd_pkg::VAL_W-1:0]      start_x,
  output logic signed [ttd_pkg::VAL_W-1:0]      start_y,
  output logic signed [ttd_pkg::VAL_W-1:0]      end_x,
  output logic signed [ttd_pkg::VAL_W-1:0]      end_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ttd_pkg::CFG_W-1:0]             cfg_data
);

  logic          q_ready, q_push, q_valid, q_pop;
  ttd_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  // event front
  ttd_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .event_kind  (event_kind),
    .event_value (event_value),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // command queue
  ttd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  // gesture back end
  ttd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gesture_kind (gesture_kind),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y)
  );

endmodule

### tb/ttd_gesture_checker.sv
// ttd_gesture_checker: watches the event, gesture and config channels of the
// touch tap/drag classifier, predicts each gesture and compares it.
// Depends on ttd_pkg.
`timescale 1ns / 1ps

module ttd_gesture_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [2:0]                        event_kind,
  input  logic signed [ttd_pkg::VAL_W-1:0]  event_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [2:0]                        gesture_kind,
  input  logic signed [ttd_pkg::VAL_W-1:0]  start_x,
  input  logic signed [ttd_pkg::VAL_W-1:0]  start_y,
  input  logic signed [ttd_pkg::VAL_W-1:0]  end_x,
  input  logic signed [ttd_pkg::VAL_W-1:0]  end_y,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttd_pkg::CFG_W-1:0]         cfg_data,
  output int                                mismatches,
  output int                                gestures_pending
);

  typedef struct packed {
    ttd_pkg::gesture_t kind;
    ttd_pkg::pos_t     sx;
    ttd_pkg::pos_t     sy;
    ttd_pkg::pos_t     ex;
    ttd_pkg::pos_t     ey;
  } gesture_rec_t;

  // mirrored registers
  logic                      stream_on;
  logic [ttd_pkg::CFG_W-1:0] drag_limit;
  logic [ttd_pkg::CFG_W-1:0] step_min;

  // mirrored gesture state
  ttd_pkg::pos_t cur_x, cur_y, press_x, press_y, moved_x, moved_y;
  logic          touching, pressed, streaming;

  gesture_rec_t gestures_due[$];

  function automatic logic known(ttd_pkg::pos_t p);
    return !p[ttd_pkg::POS_W-1];
  endfunction

  function automatic int axis_gap(ttd_pkg::pos_t a, ttd_pkg::pos_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  task automatic press_down();
    touching = 1'b1;
    pressed  = 1'b1;
    press_x  = cur_x;
    press_y  = cur_y;
  endtask

  // frame sync: decide whether a gesture is reported, per the current mode
  task automatic classify_sync(output logic fired, output gesture_rec_t rec);
    int travel;
    fired = 1'b0;
    rec   = '0;
    // a press whose point was unknown picks up the point at the next sync
    if (touching && pressed && !known(press_x)) begin
      press_x = cur_x;
      press_y = cur_y;
    end
    if (stream_on) begin
      if (touching && !streaming && known(cur_x) && known(cur_y)) begin
        rec.kind  = ttd_pkg::GK_DOWN;
        fired     = 1'b1;
        streaming = 1'b1;
      end else if (touching && streaming) begin
        travel = axis_gap(cur_x, moved_x) + axis_gap(cur_y, moved_y);
        if (travel >= int'(step_min)) begin
          rec.kind = ttd_pkg::GK_MOVE;
          fired    = 1'b1;
        end
      end else if (!touching && streaming) begin
        rec.kind  = ttd_pkg::GK_UP;
        fired     = 1'b1;
        streaming = 1'b0;
        pressed   = 1'b0;
        press_x   = ttd_pkg::POS_UNKNOWN;
        press_y   = ttd_pkg::POS_UNKNOWN;
      end
      if (fired && rec.kind != ttd_pkg::GK_UP) begin
        moved_x = cur_x;
        moved_y = cur_y;
      end
    end else if (!touching && pressed && known(cur_x) && known(cur_y)) begin
      fired = 1'b1;
      if (known(press_x) && (axis_gap(cur_x, press_x) > int'(drag_limit) ||
                             axis_gap(cur_y, press_y) > int'(drag_limit))) begin
        rec.kind = ttd_pkg::GK_DRAG;
        rec.sx   = press_x;
        rec.sy   = press_y;
      end else begin
        rec.kind = ttd_pkg::GK_TAP;
      end
      pressed = 1'b0;
      press_x = ttd_pkg::POS_UNKNOWN;
      press_y = ttd_pkg::POS_UNKNOWN;
    end
    rec.ex = cur_x;
    rec.ey = cur_y;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    logic         fired;
    gesture_rec_t rec;
    gesture_rec_t due;
    if (rst) begin
      stream_on  = 1'b0;
      drag_limit = ttd_pkg::RESET_THRESHOLD;
      step_min   = ttd_pkg::RESET_STEP;
      cur_x      = ttd_pkg::POS_UNKNOWN;
      cur_y      = ttd_pkg::POS_UNKNOWN;
      press_x    = ttd_pkg::POS_UNKNOWN;
      press_y    = ttd_pkg::POS_UNKNOWN;
      moved_x    = ttd_pkg::POS_UNKNOWN;
      moved_y    = ttd_pkg::POS_UNKNOWN;
      touching   = 1'b0;
      pressed    = 1'b0;
      streaming  = 1'b0;
      gestures_due.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ttd_pkg::CFG_STREAM_MODE: stream_on  = cfg_data[0];
          ttd_pkg::CFG_DRAG_LIMIT:  drag_limit = cfg_data;
          ttd_pkg::CFG_MOVE_STEP:   step_min   = cfg_data;
          default: ;
        endcase
      end
      // gesture transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (gestures_due.size() == 0) begin
          $error("gesture_kind: expected none, got %0d", gesture_kind);
          mismatches++;
        end else begin
          due = gestures_due.pop_front();
          check_field("gesture_kind", int'(due.kind), int'(gesture_kind));
          check_field("start_x", int'(due.sx), int'(start_x));
          check_field("start_y", int'(due.sy), int'(start_y));
          check_field("end_x", int'(due.ex), int'(end_x));
          check_field("end_y", int'(due.ey), int'(end_y));
        end
      end
      // event transaction updates the mirrored state
      if (in_valid && in_ready) begin
        fired = 1'b0;
        case (event_kind)
          ttd_pkg::EV_X: cur_x = event_value;
          ttd_pkg::EV_Y: cur_y = event_value;
          ttd_pkg::EV_ID: begin
            if (event_value == ttd_pkg::POS_UNKNOWN) touching = 1'b0;
            else if (!touching) press_down();
          end
          ttd_pkg::EV_BUTTON: begin
            if (event_value != 0) press_down();
            else touching = 1'b0;
          end
          ttd_pkg::EV_SYNC: classify_sync(fired, rec);
          default: ;
        endcase
        if (fired) gestures_due.push_back(rec);
      end
    end
    gestures_pending <= gestures_due.size();
  end

endmodule

### tb/touch_tap_drag_classifier_tb.sv
// touch_tap_drag_classifier_tb: drives touch events and register writes into
// the classifier with random idling on both sides; ttd_gesture_checker judges
// the gestures. Depends on ttd_pkg, ttd_gesture_checker and the RTL.
`timescale 1ns / 1ps

module touch_tap_drag_classifier_tb;

  localparam int LIMIT     = 400000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN     = 12;

  // event kinds the block ignores, and the unused register index
  localparam logic [2:0]                    EV_RSVD5  = 3'd5;
  localparam logic [2:0]                    EV_RSVD6  = 3'd6;
  localparam logic [2:0]                    EV_RSVD7  = 3'd7;
  localparam logic [ttd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [2:0]                       event_kind = ttd_pkg::EV_X;
  logic signed [ttd_pkg::VAL_W-1:0] event_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [2:0]                       gesture_kind;
  logic signed [ttd_pkg::VAL_W-1:0] start_x, start_y, end_x, end_y;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ttd_pkg::CFG_IDX_W-1:0]    cfg_index = ttd_pkg::CFG_STREAM_MODE;
  logic [ttd_pkg::CFG_W-1:0]        cfg_data = '0;

  int mismatches;
  int gestures_pending;
  int items_sent = 0;
  int cycles = 0;
  int last_pos[2] = '{0, 0};
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_served = 1'b0;

  touch_tap_drag_classifier DUT (
    .clk, .rst, .in_valid, .in_ready, .event_kind, .event_value,
    .out_valid, .out_ready, .gesture_kind, .start_x, .start_y, .end_x, .end_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ttd_gesture_checker gesture_check (
    .clk, .rst, .in_valid, .in_ready, .event_kind, .event_value,
    .out_valid, .out_ready, .gesture_kind, .start_x, .start_y, .end_x, .end_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .gestures_pending
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("touch_tap_drag_classifier_tb failed");
      $finish;
    end
  end

  // gesture receiver: random stalls, one long hold on request
  initial begin
    int   run;
    int   r;
    logic level;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        run = 0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          level = 1'b1;
          run   = $urandom_range(0, 25);
        end else if (r < 90) begin
          level = 1'b0;
          run   = $urandom_range(0, 2);
        end else begin
          level = 1'b0;
          run   = $urandom_range(8, 30);
        end
        out_ready <= level;
      end
    end
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one event transaction, preceded by a random gap
  task automatic send(logic [2:0] kind, logic [ttd_pkg::VAL_W-1:0] value);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    event_kind  <= kind;
    event_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering events until every gesture is in, then let the pipe drain
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (gestures_pending == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [ttd_pkg::CFG_IDX_W-1:0] idx,
                           logic [ttd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // coordinate mostly near the last one, sometimes anywhere or unknown
  function automatic logic [ttd_pkg::VAL_W-1:0] pick_coord(int last);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) v = last + int'($urandom_range(0, 16)) - 8;
    else if (r < 60) v = last + int'($urandom_range(0, 240)) - 120;
    else if (r < 75) v = $urandom_range(0, 65535);
    else if (r < 84) v = $urandom_range(0, 15);
    else if (r < 92) v = 65535 - int'($urandom_range(0, 15));
    else if (r < 95) return '1;
    else return {1'b1, 16'($urandom())};
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return ttd_pkg::VAL_W'(v);
  endfunction

  task automatic send_coord(logic [2:0] axis);
    logic [ttd_pkg::VAL_W-1:0] v;
    int                        slot;
    slot = (axis == ttd_pkg::EV_Y) ? 1 : 0;
    v = pick_coord(last_pos[slot]);
    if (!v[ttd_pkg::VAL_W-1]) last_pos[slot] = int'(v);
    send(axis, v);
  endtask

  task automatic send_press();
    logic [ttd_pkg::VAL_W-1:0] v;
    v = ttd_pkg::VAL_W'($urandom());
    if ($urandom_range(0, 1)) begin
      if (v == '1) v = '0;
      send(ttd_pkg::EV_ID, v);
    end else begin
      if (v == '0) v = ttd_pkg::VAL_W'(1);
      send(ttd_pkg::EV_BUTTON, v);
    end
  endtask

  task automatic send_lift();
    if ($urandom_range(0, 1)) send(ttd_pkg::EV_ID, '1);
    else send(ttd_pkg::EV_BUTTON, '0);
  endtask

  task automatic send_noise();
    send(3'($urandom_range(0, 7)), ttd_pkg::VAL_W'($urandom()));
  endtask

  // press, a few synced moves, lift and a closing sync
  task automatic play_gesture();
    int moves;
    if ($urandom_range(0, 3) != 0) send_coord(ttd_pkg::EV_X);
    if ($urandom_range(0, 3) != 0) send_coord(ttd_pkg::EV_Y);
    send_press();
    if ($urandom_range(0, 3) != 0) send(ttd_pkg::EV_SYNC, ttd_pkg::VAL_W'($urandom()));
    moves = $urandom_range(0, 6);
    repeat (moves) begin
      if ($urandom_range(0, 3) != 0) send_coord(ttd_pkg::EV_X);
      if ($urandom_range(0, 3) != 0) send_coord(ttd_pkg::EV_Y);
      if ($urandom_range(0, 9) == 0) send_press();
      if ($urandom_range(0, 19) == 0) send_noise();
      send(ttd_pkg::EV_SYNC, ttd_pkg::VAL_W'($urandom()));
    end
    send_lift();
    if ($urandom_range(0, 5) == 0) send_coord(ttd_pkg::EV_X);
    if ($urandom_range(0, 5) == 0) send_coord(ttd_pkg::EV_Y);
    send(ttd_pkg::EV_SYNC, ttd_pkg::VAL_W'($urandom()));
  endtask

  task automatic set_regs(logic mode, logic [ttd_pkg::CFG_W-1:0] thr,
                          logic [ttd_pkg::CFG_W-1:0] step);
    quiesce();
    write_reg(ttd_pkg::CFG_STREAM_MODE, {15'($urandom()), mode});
    write_reg(ttd_pkg::CFG_DRAG_LIMIT, thr);
    write_reg(ttd_pkg::CFG_MOVE_STEP, step);
  endtask

  task automatic run_phase(int count, bit pause_midway);
    int stop;
    int half;
    stop = items_sent + count;
    half = items_sent + count / 2;
    while (items_sent < stop) begin
      if (pause_midway && items_sent >= half) begin
        quiesce();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 99) < 85) play_gesture();
      else repeat ($urandom_range(1, 3)) send_noise();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lift mode at reset values: drag, unknown positions, taps
    send(ttd_pkg::EV_X, 17'd0);
    send(ttd_pkg::EV_Y, 17'd65535);
    send(ttd_pkg::EV_ID, 17'd5);
    send(ttd_pkg::EV_SYNC, '0);
    send(ttd_pkg::EV_X, 17'd65535);
    send(ttd_pkg::EV_ID, 17'd7);
    send(ttd_pkg::EV_ID, '1);
    send(ttd_pkg::EV_SYNC, '1);
    send(ttd_pkg::EV_BUTTON, 17'd1);
    send(ttd_pkg::EV_X, 17'h10000);
    send(ttd_pkg::EV_BUTTON, '0);
    send(ttd_pkg::EV_SYNC, 17'h0aaaa);
    send(ttd_pkg::EV_X, 17'd65500);
    send(ttd_pkg::EV_SYNC, 17'h15555);
    send(EV_RSVD5, 17'h1ffff);
    send(EV_RSVD6, 17'h00001);
    send(EV_RSVD7, '1);
    // tap whose press point is unknown
    send(ttd_pkg::EV_X, '1);
    send(ttd_pkg::EV_BUTTON, 17'h10000);
    send(ttd_pkg::EV_X, 17'd10);
    send(ttd_pkg::EV_BUTTON, '0);
    send(ttd_pkg::EV_SYNC, '0);

    // stream down and move, then a mode change in the middle of the gesture
    quiesce();
    write_reg(CFG_SPARE, 16'hffff);
    write_reg(ttd_pkg::CFG_STREAM_MODE, 16'h0001);
    send(ttd_pkg::EV_BUTTON, 17'd1);
    send(ttd_pkg::EV_SYNC, '0);
    send(ttd_pkg::EV_X, 17'd30);
    send(ttd_pkg::EV_SYNC, '0);
    quiesce();
    write_reg(ttd_pkg::CFG_STREAM_MODE, 16'hfffe);
    send(ttd_pkg::EV_BUTTON, '0);
    send(ttd_pkg::EV_SYNC, '0);
    // streamed up at an unknown x
    quiesce();
    write_reg(ttd_pkg::CFG_STREAM_MODE, 16'h0001);
    send(ttd_pkg::EV_X, '1);
    send(ttd_pkg::EV_SYNC, '0);

    // random gestures across register settings
    set_regs(1'b0, 16'd48, 16'd8);
    run_phase(90, 1'b0);
    set_regs(1'b1, 16'd48, 16'd8);
    hold_req = 1'b1;
    run_phase(90, 1'b0);
    set_regs(1'b0, 16'd0, 16'd8);
    steady = 1'b1;
    run_phase(80, 1'b0);
    steady = 1'b0;
    set_regs(1'b1, 16'd48, 16'd0);
    run_phase(80, 1'b1);
    set_regs(1'b0, 16'hffff, 16'd0);
    run_phase(70, 1'b0);
    set_regs(1'b1, 16'd0, 16'hffff);
    run_phase(70, 1'b0);
    set_regs(1'b1, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 40)));
    run_phase(110, 1'b0);
    set_regs(1'b0, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 40)));
    run_phase(110, 1'b0);

    quiesce();
    if (mismatches == 0 && gestures_pending == 0) begin
      $display("touch_tap_drag_classifier_tb passed");
    end else begin
      $display("touch_tap_drag_classifier_tb failed");
    end
    $finish;
  end

endmodule
